// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Beat formats, calibration word map, CRC constants and datapath widths.
// ----------------------------------------------------------------------------
package ptc_pkg;

	// Calibration word store.
	localparam int PromWords = 8;
	localparam int PromIdxW  = $clog2(PromWords);
	localparam int CfgIdxW   = 4;

	// Register indexes of the calibration words.
	localparam logic [PromIdxW-1:0] RegFactory  = PromIdxW'(0);
	localparam logic [PromIdxW-1:0] RegSens     = PromIdxW'(1);
	localparam logic [PromIdxW-1:0] RegOff      = PromIdxW'(2);
	localparam logic [PromIdxW-1:0] RegTcs      = PromIdxW'(3);
	localparam logic [PromIdxW-1:0] RegTco      = PromIdxW'(4);
	localparam logic [PromIdxW-1:0] RegTref     = PromIdxW'(5);
	localparam logic [PromIdxW-1:0] RegTempsens = PromIdxW'(6);
	localparam logic [PromIdxW-1:0] RegCrc      = PromIdxW'(PromWords - 1);

	// CRC4 over the calibration words, one byte per step.
	localparam int          CrcBytes     = 2 * PromWords;
	localparam int          CrcCntW      = $clog2(CrcBytes);
	localparam logic [15:0] CrcPoly      = 16'h3000;
	localparam logic [15:0] CrcClearMask = 16'hFFF0;

	// Temperature reference points, hundredths of a degree.
	localparam int                 TRef     = 2000;
	localparam int                 TVeryLow = -1500;
	localparam logic signed [31:0] TRefW    = 32'(TRef);

	// Widths of the offset and sensitivity intermediates.
	localparam int OffW  = 40;
	localparam int SensW = 40;

	typedef logic [15:0] prom_word_t;

	typedef struct packed {
		logic [23:0] pressure_raw;
		logic [23:0] temperature_raw;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature;
		logic signed [31:0] pressure;
		logic               calibration_ok;
	} out_item_t;

	// Calibration coefficients used by the datapath.
	typedef struct packed {
		prom_word_t c1;
		prom_word_t c2;
		prom_word_t c3;
		prom_word_t c4;
		prom_word_t c5;
		prom_word_t c6;
	} coef_t;

	// Status of the calibration check.
	typedef struct packed {
		logic busy;
		logic ok;
	} cal_status_t;

	// Beat between the compensation front end and the pressure back end.
	typedef struct packed {
		logic [23:0]             d1;
		logic signed [31:0]      temperature;
		logic signed [OffW-1:0]  off;
		logic signed [SensW-1:0] sens;
	} mid_t;

endpackage

// ----- sv/ptc_cfg.sv -----
// ----------------------------------------------------------------------------
// ptc_cfg: calibration word registers and CRC4 checker
// Holds the eight calibration words and recomputes their CRC4 one byte per
// cycle after every write.
// ----------------------------------------------------------------------------
module ptc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ptc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [15:0]                  cfg_data,
	output ptc_pkg::coef_t               coef,
	output ptc_pkg::cal_status_t         cal
);

	localparam logic [ptc_pkg::CrcCntW-1:0] LastByte =
		ptc_pkg::CrcCntW'(ptc_pkg::CrcBytes - 1);

	logic [15:0]                  prom_q [ptc_pkg::PromWords];
	logic                         busy_q;
	logic                         ok_q;
	logic [ptc_pkg::CrcCntW-1:0]  cnt_q;
	logic [15:0]                  rem_q;
	logic                         wr;
	logic [ptc_pkg::PromIdxW-1:0] word_idx;
	logic [15:0]                  word_sel;
	logic [7:0]                   byte_sel;
	logic [15:0]                  rem_nxt;

	// One byte of the CRC: fold the byte in, then eight shift steps.
	function automatic logic [15:0] crc_step(input logic [15:0] rem_in,
	                                         input logic [7:0] data);
		logic [15:0] r;
		r = rem_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			r = r[15] ? ((r << 1) ^ ptc_pkg::CrcPoly) : (r << 1);
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	// Register file; writes beyond the last word are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptc_pkg::PromWords; i++) begin
				prom_q[i] <= '0;
			end
		end else if (wr && (cfg_index < ptc_pkg::CfgIdxW'(ptc_pkg::PromWords))) begin
			prom_q[cfg_index[ptc_pkg::PromIdxW-1:0]] <= cfg_data;
		end
	end

	// Select the byte for this step; the stored CRC nibble is masked out.
	always_comb begin
		word_idx = cnt_q[ptc_pkg::CrcCntW-1:1];
		word_sel = prom_q[word_idx];
		if (word_idx == ptc_pkg::RegCrc) begin
			word_sel = word_sel & ptc_pkg::CrcClearMask;
		end
		byte_sel = cnt_q[0] ? word_sel[7:0] : word_sel[15:8];
		rem_nxt  = crc_step(rem_q, byte_sel);
	end

	// CRC sequencer: restarts on every write, result valid when idle.
	// The all-zero words after reset give a zero CRC, which matches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ok_q   <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (wr) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			cnt_q <= cnt_q + ptc_pkg::CrcCntW'(1);
			if (cnt_q == LastByte) begin
				busy_q <= 1'b0;
				ok_q   <= (rem_nxt[15:12] == prom_q[ptc_pkg::RegCrc][3:0]);
			end
		end
	end

	assign coef.c1 = prom_q[ptc_pkg::RegSens];
	assign coef.c2 = prom_q[ptc_pkg::RegOff];
	assign coef.c3 = prom_q[ptc_pkg::RegTcs];
	assign coef.c4 = prom_q[ptc_pkg::RegTco];
	assign coef.c5 = prom_q[ptc_pkg::RegTref];
	assign coef.c6 = prom_q[ptc_pkg::RegTempsens];

	assign cal.busy = busy_q;
	assign cal.ok   = ok_q;

	// A write always starts a new CRC pass.
	a_write_starts_crc: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> busy_q)
		else $error("CRC pass not started after a calibration write");

	// The pass ends after the last byte unless a new write restarts it.
	a_crc_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !wr && (cnt_q == LastByte) |=> !busy_q)
		else $error("CRC pass did not end after the last byte");

endmodule

// ----- sv/ptc_comp.sv -----
// ----------------------------------------------------------------------------
// ptc_comp: temperature, offset and sensitivity pipeline
// Six stages from the raw pair to compensated temperature, offset and
// sensitivity, including the second-order corrections.
// ----------------------------------------------------------------------------
module ptc_comp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ptc_pkg::in_item_t in_data,
	input  ptc_pkg::coef_t    coef,
	output logic              out_valid,
	input  logic              out_stall,
	output ptc_pkg::mid_t     out_data
);

	localparam int DtW    = 25;
	localparam int PrW    = DtW + 17;
	localparam int DsqW   = 2 * DtW - 1;
	localparam int DltW   = PrW - 23;
	localparam int VW     = DltW + 1;
	localparam int SqW    = 35;
	localparam int Off2W  = 39;
	localparam int Sens2W = 38;

	localparam logic signed [PrW-1:0]  Rnd23    = PrW'((1 << 23) - 1);
	localparam logic signed [PrW-1:0]  Rnd8     = PrW'((1 << 8) - 1);
	localparam logic signed [PrW-1:0]  Rnd7     = PrW'((1 << 7) - 1);
	localparam logic signed [VW-1:0]   VOfs     = VW'(ptc_pkg::TRef - ptc_pkg::TVeryLow);
	localparam logic signed [DltW-1:0] VLowLim  = DltW'(ptc_pkg::TVeryLow - ptc_pkg::TRef);

	// Stage valids and readiness.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	// Stage 1.
	logic [23:0]                   d1_s1;
	logic signed [DtW-1:0]         dt_s1;
	// Stage 2.
	logic [23:0]                   d1_s2;
	logic signed [PrW-1:0]         dtc6_s2, dtc4_s2, dtc3_s2;
	logic [DsqW-1:0]               dtsq_s2;
	// Stage 3.
	logic [23:0]                   d1_s3;
	logic signed [DltW-1:0]        dlt_s3;
	logic signed [ptc_pkg::OffW-1:0]  off1_s3;
	logic signed [ptc_pkg::SensW-1:0] sens1_s3;
	logic [17:0]                   t2lo_s3;
	logic [12:0]                   t2hi_s3;
	// Stage 4.
	logic [23:0]                   d1_s4;
	logic signed [31:0]            temp_s4;
	logic signed [ptc_pkg::OffW-1:0]  off1_s4;
	logic signed [ptc_pkg::SensW-1:0] sens1_s4;
	logic [SqW-1:0]                dltsq_s4, vsq_s4;
	logic                          lo_s4, vlo_s4;
	// Stage 5.
	logic [23:0]                   d1_s5;
	logic signed [31:0]            temp_s5;
	logic signed [ptc_pkg::OffW-1:0]  off1_s5;
	logic signed [ptc_pkg::SensW-1:0] sens1_s5;
	logic [Off2W-1:0]              off2_s5;
	logic [Sens2W-1:0]             sens2_s5;
	// Stage 6.
	ptc_pkg::mid_t                 mid_s6;

	// Combinational terms between stages.
	logic signed [2*DtW-1:0]       dtsq_full;
	logic signed [PrW-1:0]         dtc6_adj, dtc4_adj, dtc3_adj;
	logic signed [PrW-24:0]        q6;
	logic signed [PrW-8:0]         q4;
	logic signed [PrW-9:0]         q3;
	logic [DsqW+1:0]               dtsq3;
	logic signed [VW-1:0]          v;
	logic signed [2*DltW-1:0]      dltsq_full;
	logic signed [2*VW-1:0]        vsq_full;
	logic [Off2W-1:0]              dl3, v7, off2;
	logic [Sens2W-1:0]             dl5, v4, sens2;

	// Ready chain: a stage loads when it is empty or its beat moves on.
	assign rdy_s6   = !v_s6 || !out_stall;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: temperature difference against the reference.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d1_s1 <= in_data.pressure_raw;
			dt_s1 <= $signed({1'b0, in_data.temperature_raw})
			       - $signed({1'b0, coef.c5, 8'h00});
		end
	end

	// Stage 2: products of the difference with coefficients and itself.
	assign dtsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			d1_s2   <= d1_s1;
			dtc6_s2 <= dt_s1 * $signed({1'b0, coef.c6});
			dtc4_s2 <= dt_s1 * $signed({1'b0, coef.c4});
			dtc3_s2 <= dt_s1 * $signed({1'b0, coef.c3});
			dtsq_s2 <= dtsq_full[DsqW-1:0];
		end
	end

	// Stage 3: scaled first-order terms; shifts round toward zero.
	always_comb begin
		dtc6_adj = dtc6_s2 + (Rnd23 & {PrW{dtc6_s2[PrW-1]}});
		dtc4_adj = dtc4_s2 + (Rnd7 & {PrW{dtc4_s2[PrW-1]}});
		dtc3_adj = dtc3_s2 + (Rnd8 & {PrW{dtc3_s2[PrW-1]}});
		q6       = dtc6_adj[PrW-1:23];
		q4       = dtc4_adj[PrW-1:7];
		q3       = dtc3_adj[PrW-1:8];
		dtsq3    = (DsqW+2)'({dtsq_s2, 1'b0}) + (DsqW+2)'(dtsq_s2);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			d1_s3    <= d1_s2;
			dlt_s3   <= q6;
			off1_s3  <= $signed({8'd0, coef.c2, 16'd0}) + ptc_pkg::OffW'(q4);
			sens1_s3 <= $signed({9'd0, coef.c1, 15'd0}) + ptc_pkg::SensW'(q3);
			t2lo_s3  <= dtsq3[DsqW+1:33];
			t2hi_s3  <= dtsq_s2[DsqW-1:36];
		end
	end

	// Stage 4: corrected temperature, temperature band, squares for the second-order terms.
	always_comb begin
		v          = VW'(dlt_s3) + VOfs;
		dltsq_full = dlt_s3 * dlt_s3;
		vsq_full   = v * v;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			d1_s4    <= d1_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			dltsq_s4 <= dltsq_full[SqW-1:0];
			vsq_s4   <= vsq_full[SqW-1:0];
			lo_s4    <= dlt_s3[DltW-1];
			vlo_s4   <= (dlt_s3 < VLowLim);
			temp_s4  <= ptc_pkg::TRefW + 32'(dlt_s3)
			          - (dlt_s3[DltW-1] ? {14'd0, t2lo_s3} : {19'd0, t2hi_s3});
		end
	end

	// Stage 5: second-order offset and sensitivity corrections.
	always_comb begin
		dl3 = Off2W'({dltsq_s4, 1'b0}) + Off2W'(dltsq_s4);
		v7  = Off2W'({vsq_s4, 3'b0}) - Off2W'(vsq_s4);
		dl5 = Sens2W'({dltsq_s4, 2'b0}) + Sens2W'(dltsq_s4);
		v4  = Sens2W'({vsq_s4, 2'b0});
		if (lo_s4) begin
			off2  = (dl3 >> 1) + (vlo_s4 ? v7 : '0);
			sens2 = (dl5 >> 3) + (vlo_s4 ? v4 : '0);
		end else begin
			off2  = Off2W'(dltsq_s4 >> 4);
			sens2 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			d1_s5    <= d1_s4;
			temp_s5  <= temp_s4;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			off2_s5  <= off2;
			sens2_s5 <= sens2;
		end
	end

	// Stage 6: corrected offset and sensitivity.
	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			mid_s6.d1          <= d1_s5;
			mid_s6.temperature <= temp_s5;
			mid_s6.off         <= off1_s5 - $signed(ptc_pkg::OffW'(off2_s5));
			mid_s6.sens        <= sens1_s5 - $signed(ptc_pkg::SensW'(sens2_s5));
		end
	end

	assign out_valid = v_s6;
	assign out_data  = mid_s6;

	// A beat held in stage 1 by a full stage 2 keeps its data.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1 && $stable(d1_s1) && $stable(dt_s1))
		else $error("Stage 1 beat lost or changed while held");

endmodule

// ----- sv/ptc_press.sv -----
// ----------------------------------------------------------------------------
// ptc_press: compensated pressure pipeline
// Five stages: split multiply of raw pressure by sensitivity, scaling, offset
// removal and the final scaled result register.
// ----------------------------------------------------------------------------
module ptc_press (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ptc_pkg::mid_t      in_data,
	input  logic               cal_ok,
	output logic               out_valid,
	input  logic               out_stall,
	output ptc_pkg::out_item_t out_data
);

	localparam int SplitW = 19;
	localparam int HiW    = ptc_pkg::SensW - SplitW;
	localparam int PlW    = 24 + SplitW;
	localparam int PhW    = 25 + HiW;
	localparam int ProdW  = 64;
	localparam int TW     = ProdW - 21;
	localparam int QW     = TW + 1;

	localparam logic signed [ProdW-1:0] Rnd21 = ProdW'((1 << 21) - 1);
	localparam logic signed [QW-1:0]    Rnd13 = QW'((1 << 13) - 1);

	logic v_s7, v_s8, v_s9, v_s10, v_s11;
	logic rdy_s7, rdy_s8, rdy_s9, rdy_s10, rdy_s11;

	logic [PlW-1:0]                  pl_s7;
	logic signed [PhW-1:0]           ph_s7;
	logic signed [ptc_pkg::OffW-1:0] off_s7, off_s8, off_s9;
	logic signed [31:0]              temp_s7, temp_s8, temp_s9, temp_s10;
	logic signed [ProdW-1:0]         prod_s8;
	logic signed [TW-1:0]            t_s9;
	logic signed [QW-1:0]            q_s10;
	ptc_pkg::out_item_t              out_s11;

	logic signed [HiW-1:0]           sens_hi;
	logic [SplitW-1:0]               sens_lo;
	logic signed [ProdW-1:0]         prod_adj;
	logic signed [QW-1:0]            q_adj;

	// Ready chain, last stage is the output register.
	assign rdy_s11  = !v_s11 || !out_stall;
	assign rdy_s10  = !v_s10 || rdy_s11;
	assign rdy_s9   = !v_s9 || rdy_s10;
	assign rdy_s8   = !v_s8 || rdy_s9;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign in_stall = !rdy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (rdy_s7)  v_s7  <= in_valid;
			if (rdy_s8)  v_s8  <= v_s7;
			if (rdy_s9)  v_s9  <= v_s8;
			if (rdy_s10) v_s10 <= v_s9;
			if (rdy_s11) v_s11 <= v_s10;
		end
	end

	// Stage 7: raw pressure times the two halves of the sensitivity.
	assign sens_hi = in_data.sens[ptc_pkg::SensW-1:SplitW];
	assign sens_lo = in_data.sens[SplitW-1:0];

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			pl_s7   <= PlW'(in_data.d1) * PlW'(sens_lo);
			ph_s7   <= $signed({1'b0, in_data.d1}) * sens_hi;
			off_s7  <= in_data.off;
			temp_s7 <= in_data.temperature;
		end
	end

	// Stage 8: combine the partial products.
	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			prod_s8 <= (ProdW'(ph_s7) <<< SplitW) + $signed(ProdW'(pl_s7));
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// Stage 9: scale the product, rounding toward zero.
	assign prod_adj = prod_s8 + (Rnd21 & {ProdW{prod_s8[ProdW-1]}});

	always_ff @(posedge clk) begin
		if (rdy_s9) begin
			t_s9    <= prod_adj[ProdW-1:21];
			off_s9  <= off_s8;
			temp_s9 <= temp_s8;
		end
	end

	// Stage 10: remove the offset.
	always_ff @(posedge clk) begin
		if (rdy_s10) begin
			q_s10    <= QW'(t_s9) - QW'(off_s9);
			temp_s10 <= temp_s9;
		end
	end

	// Stage 11: final scaling toward zero, sign-extended to 32 bits.
	assign q_adj = q_s10 + (Rnd13 & {QW{q_s10[QW-1]}});

	always_ff @(posedge clk) begin
		if (rdy_s11) begin
			out_s11.temperature    <= temp_s10;
			out_s11.pressure       <= 32'($signed(q_adj[QW-1:13]));
			out_s11.calibration_ok <= cal_ok;
		end
	end

	assign out_valid = v_s11;
	assign out_data  = out_s11;

endmodule

// ----- sv/pressure_temp_compensation.sv -----
// ----------------------------------------------------------------------------
// pressure_temp_compensation: second-order pressure sensor compensation
// Each accepted input beat passes through the eleven pipeline stages to its result on the output.
// Throughput: one beat per cycle while the output is not stalled and no CRC pass runs.
// After each calibration write the CRC4 check runs over all sixteen bytes, one
// byte at a time, and input beats are stalled meanwhile.
// Reset clears the calibration words to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module pressure_temp_compensation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ptc_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ptc_pkg::out_item_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ptc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0]                 cfg_data
);

	ptc_pkg::coef_t       coef;
	ptc_pkg::cal_status_t cal;
	logic                 comp_in_valid;
	logic                 comp_in_stall;
	logic                 mid_valid;
	logic                 mid_stall;
	ptc_pkg::mid_t        mid_data;

	// Calibration words and CRC check.
	ptc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef),
		.cal       (cal)
	);

	// Hold off input beats while the CRC pass runs.
	assign comp_in_valid = in_valid && !cal.busy;
	assign in_stall      = cal.busy || comp_in_stall;

	ptc_comp u_comp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (comp_in_valid),
		.in_stall  (comp_in_stall),
		.in_data   (in_data),
		.coef      (coef),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.out_data  (mid_data)
	);

	ptc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.in_data   (mid_data),
		.cal_ok    (cal.ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// No input beat is taken in the cycle after a calibration write.
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("Input accepted while the CRC check is pending");

endmodule
